// ===== hw/rtl/gma_pkg.sv =====
// Package for the gated moving average core: field widths, limits and
// the transaction, result and window write types used across the modules.
// No dependencies.
package gma_pkg;

  localparam int unsigned DATA_W         = 16;
  localparam int unsigned TOL_W          = 15;
  localparam int unsigned ERR_W          = 16;
  localparam int unsigned WARN_W         = 8;
  localparam int unsigned WARM_W         = 2;
  localparam int unsigned WINDOW_LEN_DEF = 8;
  localparam int unsigned RESTART_LIMIT  = 5;
  localparam int unsigned READY_PASSES   = 2;
  localparam int unsigned WARM_MAX       = 3;
  localparam logic [TOL_W-1:0] TOL_RESET = 15'd100;

  typedef enum logic {
    MODE_READ   = 1'b0,
    MODE_PRESET = 1'b1
  } mode_e;

  typedef struct packed {
    logic                     sample_ok;
    mode_e                    mode;
    logic signed [DATA_W-1:0] sample;
  } item_t;

  typedef struct packed {
    logic [WARN_W-1:0]        warning_count;
    logic [ERR_W-1:0]         errors_in_row;
    logic signed [DATA_W-1:0] window_average;
    logic signed [DATA_W-1:0] latest_value;
    logic                     ready_res;
  } result_t;

  typedef struct packed {
    logic                     we;
    logic                     preset;
    logic signed [DATA_W-1:0] data;
  } win_wr_t;

endpackage

// ===== hw/rtl/gma_avg_div.sv =====
// Divides the signed window sum by the window length, truncating toward
// zero, using a reciprocal multiplication. Depends on gma_pkg.
module gma_avg_div #(
  parameter int unsigned WINDOW_LEN = gma_pkg::WINDOW_LEN_DEF,
  parameter int unsigned SUM_W      = gma_pkg::DATA_W + $clog2(WINDOW_LEN)
) (
  input  logic signed [SUM_W-1:0]           sum_i,
  output logic signed [gma_pkg::DATA_W-1:0] avg_o
);
  import gma_pkg::*;

  localparam int unsigned LOG_D  = $clog2(WINDOW_LEN);
  localparam int unsigned SHIFT  = SUM_W + LOG_D;
  localparam int unsigned M_W    = SUM_W + 2;
  localparam int unsigned PROD_W = SUM_W + M_W;
  localparam longint unsigned MULT_L =
    ((64'd1 << SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [M_W-1:0] MULT = M_W'(MULT_L);

  logic              neg;
  logic [SUM_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] quot;

  always_comb begin
    neg   = sum_i[SUM_W-1];
    mag   = neg ? (~sum_i + SUM_W'(1)) : sum_i;
    prod  = PROD_W'(mag) * PROD_W'(MULT);
    quot  = DATA_W'(prod >> SHIFT);
    avg_o = neg ? $signed(~quot + DATA_W'(1)) : $signed(quot);
  end

endmodule

// ===== hw/rtl/gma_window.sv =====
// Sample window storage: a memory with a registered read, per-entry
// fresh bits and a preset value that stands in for stale entries. Depends on gma_pkg.
module gma_window #(
  parameter int unsigned WINDOW_LEN = gma_pkg::WINDOW_LEN_DEF,
  parameter int unsigned AW         = $clog2(WINDOW_LEN)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gma_pkg::win_wr_t                  wr_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic [AW-1:0]                     rd_addr_i,
  input  logic [AW-1:0]                     cur_addr_i,
  output logic signed [gma_pkg::DATA_W-1:0] old_o
);
  import gma_pkg::*;

  logic signed [DATA_W-1:0] mem [WINDOW_LEN];
  logic signed [DATA_W-1:0] rd_q;
  logic signed [DATA_W-1:0] preset_q;
  logic [WINDOW_LEN-1:0]    fresh_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_addr_i] <= wr_i.data;
    end
    if (wr_i.we && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_i.data;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q  <= '0;
      preset_q <= '0;
    end else if (wr_i.preset) begin
      fresh_q  <= '0;
      preset_q <= wr_i.data;
    end else if (wr_i.we) begin
      fresh_q[wr_addr_i] <= 1'b1;
    end
  end

  assign old_o = fresh_q[cur_addr_i] ? rd_q : preset_q;

  a_preset_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(wr_i.preset) |-> (fresh_q == '0))
    else $error("Window entries stayed fresh after a preset.");

endmodule

// ===== hw/rtl/gma_ctrl.sv =====
// Per-transaction update of the running sum, average, warm-up state and
// error counters, and assembly of the result. Depends on gma_pkg and gma_avg_div.
module gma_ctrl #(
  parameter int unsigned WINDOW_LEN = gma_pkg::WINDOW_LEN_DEF,
  parameter int unsigned AW         = $clog2(WINDOW_LEN)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              advance_i,
  input  gma_pkg::item_t                    item_i,
  input  logic [gma_pkg::TOL_W-1:0]         tol_i,
  input  logic signed [gma_pkg::DATA_W-1:0] old_i,
  output gma_pkg::win_wr_t                  wr_o,
  output logic [AW-1:0]                     wr_addr_o,
  output logic [AW-1:0]                     rd_addr_o,
  output gma_pkg::result_t                  result_o
);
  import gma_pkg::*;

  localparam int unsigned SUM_W    = DATA_W + AW;
  localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_LEN - 1);
  localparam logic [AW-1:0] POS_ONE  = AW'(1);
  localparam logic signed [SUM_W-1:0] LEN_S = SUM_W'(WINDOW_LEN);

  logic [AW-1:0]            pos_q, pos_d, pos_inc;
  logic [WARM_W-1:0]        warm_q, warm_d;
  logic                     ready_q, ready_d;
  logic [ERR_W-1:0]         err_q, err_d, err_inc;
  logic [WARN_W-1:0]        warn_q, warn_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d, sum_acc, v_ext;
  logic signed [DATA_W-1:0] avg_q, avg_d, avg_acc;
  logic signed [DATA_W-1:0] last_q, last_d;
  logic signed [DATA_W+1:0] v_w, hi, lo;
  logic                     in_band, accept, restart;

  gma_avg_div #(
    .WINDOW_LEN(WINDOW_LEN),
    .SUM_W     (SUM_W)
  ) u_div (
    .sum_i(sum_acc),
    .avg_o(avg_acc)
  );

  always_comb begin
    v_ext   = SUM_W'(item_i.sample);
    sum_acc = sum_q + v_ext - SUM_W'(old_i);
    v_w     = (DATA_W+2)'(item_i.sample);
    hi      = (DATA_W+2)'(avg_q) + $signed({3'b000, tol_i});
    lo      = (DATA_W+2)'(avg_q) - $signed({3'b000, tol_i});
    in_band = !((v_w > hi) || (v_w < lo));
    err_inc = (err_q == '1) ? err_q : err_q + ERR_W'(1);
    pos_inc = (pos_q == LAST_POS) ? '0 : pos_q + POS_ONE;
    accept  = ready_q ? in_band : ((warm_q == '0) || in_band);
  end

  always_comb begin
    pos_d   = pos_q;
    warm_d  = warm_q;
    ready_d = ready_q;
    err_d   = err_q;
    warn_d  = warn_q;
    sum_d   = sum_q;
    avg_d   = avg_q;
    last_d  = last_q;
    restart = 1'b0;
    wr_o    = '{we: 1'b0, preset: 1'b0, data: item_i.sample};
    if (advance_i) begin
      if (item_i.mode == MODE_PRESET) begin
        wr_o.preset = 1'b1;
        sum_d       = v_ext * LEN_S;
        avg_d       = item_i.sample;
        last_d      = item_i.sample;
      end else if (!item_i.sample_ok) begin
        err_d   = err_inc;
        restart = ready_q && (err_inc > ERR_W'(RESTART_LIMIT));
      end else begin
        if (accept) begin
          err_d    = '0;
          sum_d    = sum_acc;
          avg_d    = avg_acc;
          last_d   = item_i.sample;
          pos_d    = pos_inc;
          wr_o.we  = 1'b1;
        end else begin
          err_d  = err_inc;
          warn_d = warn_q + WARN_W'(1);
        end
        if (ready_q) begin
          restart = err_d > ERR_W'(RESTART_LIMIT);
        end else begin
          if ((pos_d == '0) && (warm_q < WARM_W'(WARM_MAX))) begin
            warm_d = warm_q + WARM_W'(1);
          end
          if (warm_d >= WARM_W'(READY_PASSES)) begin
            ready_d = 1'b1;
          end
        end
      end
      if (restart) begin
        ready_d = 1'b0;
        warm_d  = '0;
        pos_d   = POS_ONE;
      end
    end
  end

  always_comb begin
    result_o.ready_res      = ready_d;
    result_o.latest_value   = ready_d ? last_d : '0;
    result_o.window_average = ready_d ? avg_d : '0;
    result_o.errors_in_row  = err_d;
    result_o.warning_count  = warn_d;
  end

  assign wr_addr_o = pos_q;
  assign rd_addr_o = pos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= POS_ONE;
      warm_q  <= '0;
      ready_q <= 1'b0;
      err_q   <= '0;
      warn_q  <= '0;
      sum_q   <= '0;
      avg_q   <= '0;
      last_q  <= '0;
    end else begin
      pos_q   <= pos_d;
      warm_q  <= warm_d;
      ready_q <= ready_d;
      err_q   <= err_d;
      warn_q  <= warn_d;
      sum_q   <= sum_d;
      avg_q   <= avg_d;
      last_q  <= last_d;
    end
  end

  a_restart_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(ready_q) |-> (err_q > ERR_W'(RESTART_LIMIT)))
    else $error("Warm-up restarted without a long error run.");

  a_warm_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (warm_q >= WARM_W'(READY_PASSES)) |-> ready_q)
    else $error("Enough warm-up passes seen but block not ready.");

endmodule

// ===== hw/rtl/gated_moving_average_core.sv =====
// Top level of the gated moving average: stream ports, input and result
// registers, tolerance register. Depends on gma_pkg, gma_window and gma_ctrl.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         s_axis_tvalid/tready      tdata: sample; tuser: mode, sample_ok
//   m_axis    out        m_axis_tvalid/tready      tdata: latest, average, errors, warnings
//   cfg       in         cfg_we_i (always taken)   cfg_wdata_i: tolerance_hundredths
//
// One transaction per cycle while results are taken: each item is held in the input
// register, and its result is registered into the result register when it advances.
// The running-sum add followed by the reciprocal multiply sets the critical path.
// Reset clears the window, counters and state; no clearing pass is needed.
// A stalled result holds its register while one further input is still taken.
module gated_moving_average_core #(
  parameter int unsigned WINDOW_LEN = gma_pkg::WINDOW_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [15:0] sample
  input  logic [1:0]                  s_axis_tuser,  // [0] mode, [1] sample_ok
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [15:0] latest_value, [31:16] window_average, [47:32] errors_in_row,
  // [55:48] warning_count
  output logic [55:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,  // [0] ready_res
  input  logic                        cfg_we_i,
  input  logic [gma_pkg::TOL_W-1:0]   cfg_wdata_i
);
  import gma_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_LEN);

  logic                     in_valid_q;
  item_t                    in_item_q;
  logic                     out_valid_q;
  result_t                  out_q;
  result_t                  result;
  logic [TOL_W-1:0]         tol_q;
  logic                     advance;
  win_wr_t                  win_wr;
  logic [AW-1:0]            wr_addr, rd_addr;
  logic signed [DATA_W-1:0] old_val;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item_q <= '{sample_ok: s_axis_tuser[1], mode: mode_e'(s_axis_tuser[0]),
                     sample: s_axis_tdata};
    end
    if (advance) begin
      out_q <= result;
    end
  end

  gma_window #(
    .WINDOW_LEN(WINDOW_LEN),
    .AW        (AW)
  ) u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (win_wr),
    .wr_addr_i (wr_addr),
    .rd_addr_i (rd_addr),
    .cur_addr_i(wr_addr),
    .old_o     (old_val)
  );

  gma_ctrl #(
    .WINDOW_LEN(WINDOW_LEN),
    .AW        (AW)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .advance_i(advance),
    .item_i   (in_item_q),
    .tol_i    (tol_q),
    .old_i    (old_val),
    .wr_o     (win_wr),
    .wr_addr_o(wr_addr),
    .rd_addr_o(rd_addr),
    .result_o (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.ready_res;
  assign m_axis_tdata  = {out_q.warning_count, out_q.errors_in_row,
                          out_q.window_average, out_q.latest_value};

  a_not_ready_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("Values shown while the block is not initialized.");

endmodule

// ===== tb/gated_moving_average_core_test.sv =====
// Self-checking testbench for gated_moving_average_core: drives sample
// transactions and tolerance writes, and checks every result against a predictor.
// Depends on gma_pkg and the gated_moving_average_core RTL.
`timescale 1ns / 100ps

import gma_pkg::*;

class gma_scoreboard;
  localparam int WIN_LEN = WINDOW_LEN_DEF;

  int tol;
  int cells[WIN_LEN];
  int run_sum;
  int wr_pos;
  int avg;
  int last_taken;
  bit ready;
  int warm;
  int err_run;
  int warn_total;
  result_t pending_outputs[$];
  int fail_count;

  function new();
    clear();
    fail_count = 0;
  endfunction

  function void clear();
    tol = int'(TOL_RESET);
    foreach (cells[i]) cells[i] = 0;
    run_sum = 0;
    avg = 0;
    last_taken = 0;
    err_run = 0;
    warn_total = 0;
    restart();
  endfunction

  function void restart();
    ready = 1'b0;
    warm = 0;
    wr_pos = 1 % WIN_LEN;
  endfunction

  function bit in_band(int v);
    return !(v > avg + tol || v < avg - tol);
  endfunction

  function void bump_run();
    if (err_run < 65535) err_run++;
  endfunction

  function void take(int v);
    err_run = 0;
    run_sum += v - cells[wr_pos];
    cells[wr_pos] = v;
    last_taken = v;
    avg = run_sum / WIN_LEN;
    wr_pos = (wr_pos + 1) % WIN_LEN;
  endfunction

  function void refuse();
    bump_run();
    warn_total = (warn_total + 1) % 256;
  endfunction

  function void note_sample(item_t it);
    int v;
    result_t r;
    v = $signed(it.sample);
    if (it.mode == MODE_PRESET) begin
      foreach (cells[i]) cells[i] = v;
      run_sum = v * WIN_LEN;
      last_taken = v;
      avg = v;
    end else if (!it.sample_ok) begin
      bump_run();
      if (ready && err_run > RESTART_LIMIT) restart();
    end else if (ready) begin
      if (in_band(v)) take(v);
      else refuse();
      if (err_run > RESTART_LIMIT) restart();
    end else begin
      if (warm == 0 || in_band(v)) take(v);
      else refuse();
      if (wr_pos == 0 && warm < WARM_MAX) warm++;
      if (warm >= READY_PASSES) ready = 1'b1;
    end
    r.ready_res      = ready;
    r.latest_value   = ready ? last_taken[15:0] : '0;
    r.window_average = ready ? avg[15:0] : '0;
    r.errors_in_row  = err_run[15:0];
    r.warning_count  = warn_total[7:0];
    pending_outputs.push_back(r);
  endfunction

  function void match_output(logic [55:0] data, logic user);
    result_t got, want;
    got.latest_value   = data[15:0];
    got.window_average = data[31:16];
    got.errors_in_row  = data[47:32];
    got.warning_count  = data[55:48];
    got.ready_res      = user;
    if (pending_outputs.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result: latest %0d avg %0d ready %0b errs %0d warns %0d",
                 got.latest_value, got.window_average, got.ready_res,
                 got.errors_in_row, got.warning_count);
      return;
    end
    want = pending_outputs.pop_front();
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display({"mismatch: expected latest %0d avg %0d ready %0b errs %0d warns %0d,",
                  " got latest %0d avg %0d ready %0b errs %0d warns %0d"},
                 want.latest_value, want.window_average, want.ready_res,
                 want.errors_in_row, want.warning_count,
                 got.latest_value, got.window_average, got.ready_res,
                 got.errors_in_row, got.warning_count);
    end
  endfunction
endclass

module gated_moving_average_core_test;
  localparam int WIN_LEN = WINDOW_LEN_DEF;
  localparam int CYCLE_LIMIT = 40000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [15:0]       s_axis_tdata = '0;
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [55:0]       m_axis_tdata;
  logic              m_axis_tuser;
  logic              cfg_we_i = 1'b0;
  logic [TOL_W-1:0]  cfg_wdata_i = '0;

  gma_scoreboard sb;
  int src_idle_pct = 10;
  int sink_idle_pct = 53;
  int cycle_count = 0;
  int burst_left = 0;
  bit burst_invalid = 1'b0;
  int tol_plan[6];
  int fails;

  gated_moving_average_core #(
    .WINDOW_LEN(WIN_LEN)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("gated_moving_average_core_test: done, errors");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Outputs are stable between edges, so each transaction is checked at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.match_output(m_axis_tdata, m_axis_tuser);
  end

  function automatic item_t make_item(mode_e m, bit ok, int v);
    item_t it;
    it.mode = m;
    it.sample_ok = ok;
    it.sample = v[15:0];
    return it;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int outside_band();
    int off;
    off = sb.tol + 1 + int'($urandom_range(300));
    return clamp16($urandom_range(1) ? sb.avg + off : sb.avg - off);
  endfunction

  function automatic item_t pick_item();
    int roll, v;
    if (burst_left > 0) begin
      burst_left--;
      if (burst_invalid) return make_item(MODE_READ, 1'b0, $urandom);
      return make_item(MODE_READ, 1'b1, outside_band());
    end
    roll = $urandom_range(99);
    if (roll < 5) begin
      burst_left = $urandom_range(1, 8);
      burst_invalid = 1'($urandom_range(1));
    end
    if (roll < 62) begin
      if ($urandom_range(4) == 0) v = $urandom_range(1) ? sb.avg + sb.tol : sb.avg - sb.tol;
      else v = sb.avg + int'($urandom_range(2 * sb.tol)) - sb.tol;
      return make_item(MODE_READ, 1'b1, clamp16(v));
    end
    if (roll < 72) return make_item(MODE_READ, 1'b1, outside_band());
    if (roll < 82) return make_item(MODE_READ, 1'b1, $urandom);
    if (roll < 92) return make_item(MODE_READ, 1'b0, $urandom);
    return make_item(MODE_PRESET, 1'($urandom_range(1)), $urandom);
  endfunction

  task automatic send_item(item_t it);
    bit rdy;
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it.sample;
    s_axis_tuser  <= {it.sample_ok, it.mode};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready;
      @(posedge clk_i);
    end while (!rdy);
    sb.note_sample(it);
  endtask

  task automatic settle(int extra);
    s_axis_tvalid <= 1'b0;
    while (sb.pending_outputs.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_tolerance(int t);
    settle(4);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= t[TOL_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.tol = t;
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(make_item(MODE_READ, 1'b1, 32767));
    send_item(make_item(MODE_READ, 1'b1, -32768));
    send_item(make_item(MODE_READ, 1'b0, 12345));
    send_item(make_item(MODE_PRESET, 1'b0, 32767));
    send_item(make_item(MODE_PRESET, 1'b1, -32768));
    send_item(make_item(MODE_PRESET, 1'b1, 0));
    send_item(make_item(MODE_READ, 1'b1, 100));
    send_item(make_item(MODE_READ, 1'b1, -100));
    send_item(make_item(MODE_READ, 1'b1, 101));
    send_item(make_item(MODE_READ, 1'b1, -101));
    repeat (7) send_item(make_item(MODE_READ, 1'b1, 0));
    repeat (6) send_item(make_item(MODE_READ, 1'b0, -1));
    send_item(make_item(MODE_READ, 1'b1, 0));

    tol_plan = '{0, 32767, 1, 100, 350, 0};
    tol_plan[5] = $urandom_range(32767);
    foreach (tol_plan[k]) begin
      if (k == 2) begin
        src_idle_pct = 53;
        sink_idle_pct = 10;
      end else if (k == 4) begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      write_tolerance(tol_plan[k]);
      repeat (210) send_item(pick_item());
    end

    write_tolerance(25);
    repeat (20) send_item(pick_item());

    settle(10);
    fails = sb.fail_count + sb.pending_outputs.size();
    if (fails == 0) begin
      $display("gated_moving_average_core_test: done, clean");
    end else begin
      $display("gated_moving_average_core_test: done, errors");
    end
    $finish;
  end
endmodule
